[sv/cocsr_pkg.sv]
// ----------------------------------------------------------------------------
// cocsr_pkg
// Shared types, widths and codes of the sparse triplet to row format converter.
// ----------------------------------------------------------------------------
package cocsr_pkg;

	localparam int MaxEntries = 1024;
	localparam int MaxRows    = 1024;
	localparam int AddrW      = 10;
	localparam int RowW       = 10;
	localparam int ColW       = 16;
	localparam int ValW       = 64;
	localparam int CntW       = 11;
	localparam int PtrAddrW   = 11;
	localparam int InDataW    = 104;
	localparam int OutDataW   = 120;

	localparam logic [2:0] RegNumRows = 3'd0;

	typedef enum logic [1:0] {
		FUNC_APPEND      = 2'd0,
		FUNC_COMPRESS    = 2'd1,
		FUNC_READ_ENTRY  = 2'd2,
		FUNC_READ_PTR    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_ROW_RANGE = 2'd2,
		STAT_BAD_READ  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_KEY,
		S_CMP,
		S_PUT,
		S_PTR
	} state_t;

	typedef struct packed {
		logic [ValW-1:0] val;
		logic [ColW-1:0] col;
		logic [RowW-1:0] row;
	} entry_t;

	typedef struct packed {
		logic                e_we;
		logic [AddrW-1:0]    e_waddr;
		entry_t              e_wdata;
		logic [AddrW-1:0]    e_raddr;
		logic                p_we;
		logic [PtrAddrW-1:0] p_waddr;
		logic [CntW-1:0]     p_wdata;
		logic [PtrAddrW-1:0] p_raddr;
	} store_ctrl_t;

	function automatic logic key_greater(input entry_t a, input entry_t b);
		return (a.row > b.row) || ((a.row == b.row) && (a.col > b.col));
	endfunction

endpackage

[sv/cocsr_store.sv]
// ----------------------------------------------------------------------------
// cocsr_store
// Entry memory and row pointer memory, one write and one registered read each.
// ----------------------------------------------------------------------------
module cocsr_store (
	input  logic                                clk,
	input  cocsr_pkg::store_ctrl_t              ctrl,
	output cocsr_pkg::entry_t                   e_rdata,
	output logic [cocsr_pkg::CntW-1:0]          p_rdata
);

	cocsr_pkg::entry_t               emem [cocsr_pkg::MaxEntries];
	logic [cocsr_pkg::CntW-1:0]      pmem [cocsr_pkg::MaxRows+1];

	always_ff @(posedge clk) begin
		if (ctrl.e_we) begin
			emem[ctrl.e_waddr] <= ctrl.e_wdata;
		end
		e_rdata <= emem[ctrl.e_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctrl.p_we) begin
			pmem[ctrl.p_waddr] <= ctrl.p_wdata;
		end
		p_rdata <= pmem[ctrl.p_raddr];
	end

endmodule

[sv/coo_to_csr_converter_unit.sv]
// ----------------------------------------------------------------------------
// coo_to_csr_converter_unit
// Triplet store with insertion sort and row pointer build under a sequencer.
// ----------------------------------------------------------------------------
// append: result registered in the accepting cycle; reads: registered memory read, then S_READ
// compress: insertion sort (S_KEY, S_CMP, S_PUT; only for more than one entry), then pointer walk
//   (S_PTR), both paced by the single entry memory read port that sort and pointer walk share
// one item in flight; next item accepted once the result word is taken
// reset clears entry count and compressed flag and sets num_rows to 1024; memories
//   hold no reset value
module coo_to_csr_converter_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// row_index[9:0], column_index[25:10], value_bits[89:26], read_position[100:90]
	input  logic [cocsr_pkg::InDataW-1:0]     s_tdata,
	// func[1:0]
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// status[1:0], out_row[11:2], out_column[27:12], out_value_bits[91:28],
	// row_start[102:92], entry_total[113:103]
	output logic [cocsr_pkg::OutDataW-1:0]    m_tdata,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	cocsr_pkg::state_t                 state_q, state_d;
	cocsr_pkg::store_ctrl_t            ctrl;
	cocsr_pkg::entry_t                 e_rdata, key_q, in_entry;
	cocsr_pkg::func_t                  func_in, func_q;
	logic [cocsr_pkg::CntW-1:0]        p_rdata;
	logic [cocsr_pkg::CntW-1:0]        count_q, num_rows_q, n_eff, p_q, rowc_q, in_pos;
	logic [cocsr_pkg::AddrW-1:0]       i_q, j_q;
	logic [cocsr_pkg::CntW-1:0]        i_next;
	logic                              compressed_q, bad_q, m_valid_q, acc, cfg_wr;
	logic                              append_ok, gt, adv, rd_bad;
	cocsr_pkg::status_t                append_stat;
	logic [cocsr_pkg::OutDataW-1:0]    m_data_q;

	assign in_entry.row = s_tdata[9:0];
	assign in_entry.col = s_tdata[25:10];
	assign in_entry.val = s_tdata[89:26];
	assign in_pos       = s_tdata[100:90];
	assign func_in      = cocsr_pkg::func_t'(s_tuser);

	assign s_tready = (state_q == cocsr_pkg::S_IDLE) && !m_valid_q;
	assign acc      = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && (paddr[2] == cocsr_pkg::RegNumRows[2]);
	assign prdata   = (paddr[2] == cocsr_pkg::RegNumRows[2]) ? {21'd0, num_rows_q} : 32'd0;

	assign n_eff = (num_rows_q > cocsr_pkg::CntW'(cocsr_pkg::MaxRows)) ?
		cocsr_pkg::CntW'(cocsr_pkg::MaxRows) : num_rows_q;

	assign gt     = cocsr_pkg::key_greater(e_rdata, key_q);
	assign adv    = (p_q < count_q) && ({1'b0, e_rdata.row} < rowc_q);
	assign i_next = {1'b0, i_q} + 11'd1;

	always_comb begin
		append_stat = cocsr_pkg::STAT_OK;
		if (count_q >= cocsr_pkg::CntW'(cocsr_pkg::MaxEntries)) begin
			append_stat = cocsr_pkg::STAT_FULL;
		end else if ({1'b0, in_entry.row} >= n_eff) begin
			append_stat = cocsr_pkg::STAT_ROW_RANGE;
		end
		append_ok = (append_stat == cocsr_pkg::STAT_OK);
		if (func_in == cocsr_pkg::FUNC_READ_ENTRY) begin
			rd_bad = !compressed_q || (in_pos >= count_q);
		end else begin
			rd_bad = !compressed_q || (in_pos > n_eff);
		end
	end

	cocsr_store u_store (
		.clk     (clk),
		.ctrl    (ctrl),
		.e_rdata (e_rdata),
		.p_rdata (p_rdata)
	);

	always_comb begin
		state_d      = state_q;
		ctrl.e_we    = 1'b0;
		ctrl.e_waddr = count_q[cocsr_pkg::AddrW-1:0];
		ctrl.e_wdata = in_entry;
		ctrl.e_raddr = in_pos[cocsr_pkg::AddrW-1:0];
		ctrl.p_we    = 1'b0;
		ctrl.p_waddr = rowc_q;
		ctrl.p_wdata = p_q;
		ctrl.p_raddr = in_pos;
		unique case (state_q)
			cocsr_pkg::S_IDLE: begin
				if (acc) begin
					unique case (func_in)
						cocsr_pkg::FUNC_APPEND: begin
							ctrl.e_we = append_ok;
						end
						cocsr_pkg::FUNC_COMPRESS: begin
							if (count_q > 11'd1) begin
								ctrl.e_raddr = 10'd1;
								state_d      = cocsr_pkg::S_KEY;
							end else begin
								ctrl.e_raddr = '0;
								state_d      = cocsr_pkg::S_PTR;
							end
						end
						default: begin
							state_d = cocsr_pkg::S_READ;
						end
					endcase
				end
			end
			cocsr_pkg::S_READ: begin
				state_d = cocsr_pkg::S_IDLE;
			end
			cocsr_pkg::S_KEY: begin
				ctrl.e_raddr = i_q - 10'd1;
				state_d      = cocsr_pkg::S_CMP;
			end
			cocsr_pkg::S_CMP, cocsr_pkg::S_PUT: begin
				ctrl.e_we    = 1'b1;
				ctrl.e_waddr = j_q;
				if ((state_q == cocsr_pkg::S_CMP) && gt) begin
					ctrl.e_wdata = e_rdata;
					if (j_q == 10'd1) begin
						state_d = cocsr_pkg::S_PUT;
					end else begin
						ctrl.e_raddr = j_q - 10'd2;
					end
				end else begin
					ctrl.e_wdata = key_q;
					if (i_next < count_q) begin
						ctrl.e_raddr = i_next[cocsr_pkg::AddrW-1:0];
						state_d      = cocsr_pkg::S_KEY;
					end else begin
						ctrl.e_raddr = '0;
						state_d      = cocsr_pkg::S_PTR;
					end
				end
			end
			cocsr_pkg::S_PTR: begin
				if (rowc_q == n_eff) begin
					ctrl.p_we    = 1'b1;
					ctrl.p_waddr = n_eff;
					ctrl.p_wdata = count_q;
					state_d      = cocsr_pkg::S_IDLE;
				end else if (adv) begin
					ctrl.e_raddr = p_q[cocsr_pkg::AddrW-1:0] + 10'd1;
				end else begin
					ctrl.p_we    = 1'b1;
					ctrl.e_raddr = p_q[cocsr_pkg::AddrW-1:0];
				end
			end
			default: begin
				state_d = cocsr_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cocsr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			compressed_q <= 1'b0;
			num_rows_q   <= 11'd1024;
			m_valid_q    <= 1'b0;
			m_data_q     <= '0;
			func_q       <= cocsr_pkg::FUNC_APPEND;
			bad_q        <= 1'b0;
			i_q          <= '0;
			j_q          <= '0;
			p_q          <= '0;
			rowc_q       <= '0;
			key_q        <= '0;
		end else begin
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				cocsr_pkg::S_IDLE: begin
					if (acc) begin
						func_q <= func_in;
						bad_q  <= rd_bad;
						i_q    <= 10'd1;
						p_q    <= '0;
						rowc_q <= '0;
						if (func_in == cocsr_pkg::FUNC_APPEND) begin
							m_valid_q <= 1'b1;
							m_data_q  <= {6'd0, append_ok ? count_q + 11'd1 : count_q,
								101'd0, append_stat};
							if (append_ok) begin
								count_q      <= count_q + 11'd1;
								compressed_q <= 1'b0;
							end
						end
					end
				end
				cocsr_pkg::S_READ: begin
					m_valid_q <= 1'b1;
					if (bad_q) begin
						m_data_q <= {6'd0, count_q, 101'd0, cocsr_pkg::STAT_BAD_READ};
					end else if (func_q == cocsr_pkg::FUNC_READ_ENTRY) begin
						m_data_q <= {6'd0, count_q, 11'd0, e_rdata.val, e_rdata.col,
							e_rdata.row, cocsr_pkg::STAT_OK};
					end else begin
						m_data_q <= {6'd0, count_q, p_rdata, 90'd0, cocsr_pkg::STAT_OK};
					end
				end
				cocsr_pkg::S_KEY: begin
					key_q <= e_rdata;
					j_q   <= i_q;
				end
				cocsr_pkg::S_CMP, cocsr_pkg::S_PUT: begin
					if ((state_q == cocsr_pkg::S_CMP) && gt) begin
						j_q <= j_q - 10'd1;
					end else begin
						i_q <= i_next[cocsr_pkg::AddrW-1:0];
					end
				end
				cocsr_pkg::S_PTR: begin
					if (rowc_q == n_eff) begin
						compressed_q <= 1'b1;
						m_valid_q    <= 1'b1;
						m_data_q     <= {6'd0, count_q, 101'd0, cocsr_pkg::STAT_OK};
					end else if (adv) begin
						p_q <= p_q + 11'd1;
					end else begin
						rowc_q <= rowc_q + 11'd1;
					end
				end
				default: begin
				end
			endcase
			if (cfg_wr) begin
				num_rows_q   <= pwdata[10:0];
				compressed_q <= 1'b0;
			end
		end
	end

endmodule
